>>> hdl/lorenz_euler_integrator_unit_assert.svh
// ----------------------------------------------------------------------------
// lorenz euler integrator assertion macros
// shorthand for clocked implication checks on clk with synchronous rst
// ----------------------------------------------------------------------------
`ifndef LORENZ_EULER_INTEGRATOR_UNIT_ASSERT_SVH
`define LORENZ_EULER_INTEGRATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LEI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lei assertion failed");

// next-cycle implication
`define LEI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lei assertion failed");

`endif

>>> hdl/lei_pkg.sv
// ----------------------------------------------------------------------------
// lei_pkg
// shared types, codes and reset-value helpers of the lorenz euler integrator
// ----------------------------------------------------------------------------
package lei_pkg;

  localparam int LEI_FRAC_BITS = 20;
  localparam int LEI_ADDR_W    = 5;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SIGMA,
    REG_RHO,
    REG_BETA,
    REG_STEP,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } lei_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } lei_state_t;

  // phases of one step: multiply issued in a phase, its result used in the next
  typedef enum logic [2:0] {
    PH_SIG_DIFF,
    PH_X_RHOZ,
    PH_X_Y,
    PH_BETA_Z,
    PH_DX_DT,
    PH_DY_DT,
    PH_DZ_DT,
    PH_LAST
  } lei_phase_t;

  // configuration register file contents
  typedef struct packed {
    logic [30:0]        sigma;
    logic [30:0]        rho;
    logic [30:0]        beta;
    logic [30:0]        step_size;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } lei_cfg_t;

  // sequencer controls to the datapath
  typedef struct packed {
    lei_state_t state;
    lei_phase_t phase;
    logic       idle;
    logic       issue;
    logic       post;
    logic       out_load;
    logic       from_state;
  } lei_ctl_t;

  // clamp to the unsigned 31 bit range
  function automatic logic [30:0] lei_sat31(input logic [63:0] v);
    return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
  endfunction

  // clamp a 33 bit signed value to 32 bits
  function automatic logic signed [31:0] lei_sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] lei_one_q(input int f);
    logic [63:0] v;
    v = 64'd1 << f;
    return v[31:0];
  endfunction

  function automatic logic [30:0] lei_sigma_rst(input int f);
    return lei_sat31(64'd10 << f);
  endfunction

  function automatic logic [30:0] lei_rho_rst(input int f);
    return lei_sat31(64'd28 << f);
  endfunction

  function automatic logic [30:0] lei_beta_rst(input int f);
    return lei_sat31(((64'd16 << f) + 64'd3) / 64'd6);
  endfunction

  function automatic logic [30:0] lei_step_rst(input int f);
    return lei_sat31(((64'd1 << f) + 64'd50) / 64'd100);
  endfunction

endpackage

>>> hdl/lei_if.sv
// ----------------------------------------------------------------------------
// lei channel interfaces
// tick input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lei_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lei_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        elapsed;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output elapsed, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input elapsed, output ready);
endinterface

>>> hdl/lorenz_euler_integrator_unit.sv
// ----------------------------------------------------------------------------
// lorenz_euler_integrator_unit
// one forward euler step of the lorenz system per tick, signed fixed point
// ----------------------------------------------------------------------------
// Each accepted tick advances the stored point by one Euler step and returns
// the new x, y, z and elapsed time as one result transaction. A tick is taken
// in the idle state (reloading the start point on restart); in eight phases
// a single shared multiplier then forms the seven products in turn, each
// rounded and, where needed, combined with a shared saturating adder in the
// phase after it is issued. No tick is taken until the step is through. The
// result sits in an output register; if the last one is still not taken as
// a step ends, the block holds in a wait state and accepts no tick. The user
// must write configuration between ticks; the block does not enforce it.
`include "lorenz_euler_integrator_unit_assert.svh"

module lorenz_euler_integrator_unit
  import lei_pkg::*;
#(
  parameter int FRAC_BITS = LEI_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  lei_tick_if.sink              tick,
  lei_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [LEI_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic signed [31:0] ONE_Q = lei_one_q(FRAC_BITS);

  lei_cfg_t cfg;
  lei_ctl_t ctl;

  logic               accept;
  logic               out_free;
  logic signed [31:0] x, y, z;
  logic [30:0]        tm;
  logic signed [31:0] dx, dy, dz, tmp;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] mul_r;
  logic signed [31:0] add_a, add_b;
  logic               add_sub;
  logic signed [32:0] add_sum;
  logic signed [31:0] add_sat;
  logic [31:0]        tm_sum;
  logic [30:0]        tm_next;

  assign accept     = tick.valid && tick.ready;
  assign out_free   = !result.valid || result.ready;
  assign tick.ready = ctl.idle;

  lei_cfg_regs #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  lei_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .out_free(out_free),
    .ctl     (ctl)
  );

  lei_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .en (ctl.issue),
    .a  (mul_a),
    .b  (mul_b),
    .r  (mul_r)
  );

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.phase)
      PH_SIG_DIFF: begin
        mul_a = {2'b00, cfg.sigma};
        mul_b = {y[31], y} - {x[31], x};
      end
      PH_X_RHOZ: begin
        mul_a = {x[31], x};
        mul_b = {2'b00, cfg.rho} - {z[31], z};
      end
      PH_X_Y: begin
        mul_a = {x[31], x};
        mul_b = {y[31], y};
      end
      PH_BETA_Z: begin
        mul_a = {2'b00, cfg.beta};
        mul_b = {z[31], z};
      end
      PH_DX_DT: begin
        mul_a = {dx[31], dx};
        mul_b = {2'b00, cfg.step_size};
      end
      PH_DY_DT: begin
        mul_a = {dy[31], dy};
        mul_b = {2'b00, cfg.step_size};
      end
      PH_DZ_DT: begin
        mul_a = {dz[31], dz};
        mul_b = {2'b00, cfg.step_size};
      end
      default: ;
    endcase
  end

  // shared saturating adder on the rounded product
  always_comb begin
    add_a   = '0;
    add_b   = mul_r;
    add_sub = 1'b0;
    unique case (ctl.phase)
      PH_X_Y: begin
        add_a   = mul_r;
        add_b   = y;
        add_sub = 1'b1;
      end
      PH_DX_DT: begin
        add_a   = tmp;
        add_sub = 1'b1;
      end
      PH_DY_DT: add_a = x;
      PH_DZ_DT: add_a = y;
      PH_LAST:  add_a = z;
      default: ;
    endcase
    add_sum = add_sub ? ({add_a[31], add_a} - {add_b[31], add_b})
                      : ({add_a[31], add_a} + {add_b[31], add_b});
    add_sat = lei_sat32(add_sum);
  end

  // elapsed time, clamped at the top of the range
  always_comb begin
    tm_sum  = {1'b0, tm} + {1'b0, cfg.step_size};
    tm_next = tm_sum[31] ? 31'h7FFF_FFFF : tm_sum[30:0];
  end

  // point and time state
  always_ff @(posedge clk) begin
    if (rst) begin
      x  <= ONE_Q;
      y  <= ONE_Q;
      z  <= ONE_Q;
      tm <= '0;
    end else if (accept && tick.restart) begin
      x  <= cfg.start_x;
      y  <= cfg.start_y;
      z  <= cfg.start_z;
      tm <= '0;
    end else if (ctl.post) begin
      unique case (ctl.phase)
        PH_DY_DT: x <= add_sat;
        PH_DZ_DT: y <= add_sat;
        PH_LAST: begin
          z  <= add_sat;
          tm <= tm_next;
        end
        default: ;
      endcase
    end
  end

  // derivative and partial product registers
  always_ff @(posedge clk) begin
    if (ctl.post) begin
      unique case (ctl.phase)
        PH_X_RHOZ: dx  <= mul_r;
        PH_X_Y:    dy  <= add_sat;
        PH_BETA_Z: tmp <= mul_r;
        PH_DX_DT:  dz  <= add_sat;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctl.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result.pos_x <= x;
      result.pos_y <= y;
      if (ctl.from_state) begin
        result.pos_z   <= z;
        result.elapsed <= tm;
      end else begin
        result.pos_z   <= add_sat;
        result.elapsed <= tm_next;
      end
    end
  end

  // checks
  `LEI_ASSERT_NXT(a_accept_starts_run, tick.valid && tick.ready,
                  ctl.state == ST_RUN && ctl.phase == PH_SIG_DIFF)
  `LEI_ASSERT_IMP(a_result_from_step, $rose(result.valid),
                  $past(ctl.state == ST_RUN || ctl.state == ST_DONE))
  `LEI_ASSERT_IMP(a_wait_has_result, ctl.state == ST_DONE, result.valid)

endmodule

>>> hdl/lei_cfg_regs.sv
// ----------------------------------------------------------------------------
// lei_cfg_regs
// apb register file holding coefficients, step size and start point
// ----------------------------------------------------------------------------
module lei_cfg_regs
  import lei_pkg::*;
#(
  parameter int FRAC_BITS = LEI_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [LEI_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output lei_cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sigma     <= lei_sigma_rst(FRAC_BITS);
      cfg.rho       <= lei_rho_rst(FRAC_BITS);
      cfg.beta      <= lei_beta_rst(FRAC_BITS);
      cfg.step_size <= lei_step_rst(FRAC_BITS);
      cfg.start_x   <= lei_one_q(FRAC_BITS);
      cfg.start_y   <= lei_one_q(FRAC_BITS);
      cfg.start_z   <= lei_one_q(FRAC_BITS);
    end else if (wr) begin
      unique case (idx)
        REG_SIGMA:   cfg.sigma     <= pwdata[30:0];
        REG_RHO:     cfg.rho       <= pwdata[30:0];
        REG_BETA:    cfg.beta      <= pwdata[30:0];
        REG_STEP:    cfg.step_size <= pwdata[30:0];
        REG_START_X: cfg.start_x   <= pwdata;
        REG_START_Y: cfg.start_y   <= pwdata;
        REG_START_Z: cfg.start_z   <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_SIGMA:   prdata = {1'b0, cfg.sigma};
      REG_RHO:     prdata = {1'b0, cfg.rho};
      REG_BETA:    prdata = {1'b0, cfg.beta};
      REG_STEP:    prdata = {1'b0, cfg.step_size};
      REG_START_X: prdata = cfg.start_x;
      REG_START_Y: prdata = cfg.start_y;
      REG_START_Z: prdata = cfg.start_z;
      default:     prdata = '0;
    endcase
  end

endmodule

>>> hdl/lei_mul.sv
// ----------------------------------------------------------------------------
// lei_mul
// shared registered multiplier with round half up and 32 bit saturation
// ----------------------------------------------------------------------------
module lei_mul
  import lei_pkg::*;
#(
  parameter int FRAC_BITS = LEI_FRAC_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [31:0] r
);

  localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] MAX_V = 66'sd2147483647;
  localparam logic signed [65:0] MIN_V = -66'sd2147483648;

  logic signed [65:0] prod;
  logic signed [65:0] rounded;
  logic signed [65:0] shifted;

  // exact product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

  // round to the fraction grid and clamp
  always_comb begin
    rounded = prod + HALF;
    shifted = rounded >>> FRAC_BITS;
    if (shifted > MAX_V) begin
      r = 32'sh7FFF_FFFF;
    end else if (shifted < MIN_V) begin
      r = 32'sh8000_0000;
    end else begin
      r = shifted[31:0];
    end
  end

endmodule

>>> hdl/lei_ctrl.sv
// ----------------------------------------------------------------------------
// lei_ctrl
// sequencer stepping the shared multiplier through one euler step
// ----------------------------------------------------------------------------
module lei_ctrl
  import lei_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic     out_free,
  output lei_ctl_t ctl
);

  lei_state_t state, state_next;
  lei_phase_t phase, phase_next;

  // state and phase registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_SIG_DIFF;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          phase_next = PH_SIG_DIFF;
        end
      end
      ST_RUN: begin
        if (phase == PH_LAST) begin
          state_next = out_free ? ST_IDLE : ST_DONE;
        end else begin
          phase_next = lei_phase_t'(phase + 3'd1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.state      = state;
    ctl.phase      = phase;
    ctl.idle       = (state == ST_IDLE);
    ctl.issue      = (state == ST_RUN) && (phase != PH_LAST);
    ctl.post       = (state == ST_RUN) && (phase != PH_SIG_DIFF);
    ctl.out_load   = out_free && (((state == ST_RUN) && (phase == PH_LAST))
                                  || (state == ST_DONE));
    ctl.from_state = (state == ST_DONE);
  end

endmodule
